@@ rtl/core/mlnco_pkg.sv @@
`default_nettype none

package mlnco_pkg;

    // Default configuration of the oscillator.
    localparam int unsigned PHASE_BITS_DEF  = 32;
    localparam int unsigned LANES_DEF       = 4;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // Fixed widths of the step register and the packed sample words.
    localparam int unsigned STEP_W = 32;
    localparam int unsigned WORD_W = 64;

    typedef logic [WORD_W-1:0] t_word;

    // 1.0 in Q1.63 and pi/4 in Q0.64.
    localparam t_word ONE_Q63        = 64'h8000_0000_0000_0000;
    localparam t_word PI_QUARTER_Q64 = 64'hC90F_DAA2_2168_C234;

    // Horner terms of the cosine and sine series.
    localparam int unsigned TERMS = 10;

    // Register stages of the 64x64 high product and of one series term.
    localparam int unsigned MUL_LAT  = 2;
    localparam int unsigned STEP_LAT = 2 * MUL_LAT + 2;

    // Phase input of a lane to its registered samples.
    localparam int unsigned LANE_LAT = 2 + 3 * MUL_LAT + TERMS * STEP_LAT;

endpackage

`default_nettype wire

@@ rtl/core/mlnco_mulhi.sv @@
`default_nettype none

// High 64 bits of a 64x64 unsigned product, in two register stages.
module mlnco_mulhi (
    input  logic              i_clk,
    input  logic              i_en,
    input  mlnco_pkg::t_word  i_a,
    input  mlnco_pkg::t_word  i_b,
    output mlnco_pkg::t_word  o_hi
);

    logic [31:0]      a0, a1, b0, b1;
    mlnco_pkg::t_word r_p00, r_p01, r_p10, r_p11;
    mlnco_pkg::t_word mid, n_hi, r_hi;

    assign a0 = i_a[31:0];
    assign a1 = i_a[63:32];
    assign b0 = i_b[31:0];
    assign b1 = i_b[63:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 64'(a0) * 64'(b0);
            r_p01 <= 64'(a0) * 64'(b1);
            r_p10 <= 64'(a1) * 64'(b0);
            r_p11 <= 64'(a1) * 64'(b1);
        end
    end

    always_comb begin
        mid  = {32'd0, r_p00[63:32]} + {32'd0, r_p01[31:0]} + {32'd0, r_p10[31:0]};
        n_hi = r_p11 + {32'd0, r_p01[63:32]} + {32'd0, r_p10[63:32]} + {32'd0, mid[63:32]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi <= n_hi;
        end
    end

    assign o_hi = r_hi;

endmodule

`default_nettype wire

@@ rtl/core/mlnco_step.sv @@
`default_nettype none

// One Horner term: b_next = 1.0 - floor(hi(x2 * b) / DIV).
// The quotient comes from a reciprocal product that is low by at most one,
// then one compare fixes it.
module mlnco_step #(
    parameter int unsigned DIV = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  mlnco_pkg::t_word  i_x2,
    input  mlnco_pkg::t_word  i_b,
    output mlnco_pkg::t_word  o_b
);

    localparam mlnco_pkg::t_word DIV_W = mlnco_pkg::t_word'(DIV);
    localparam mlnco_pkg::t_word RECIP = 64'hFFFF_FFFF_FFFF_FFFF / DIV_W;

    mlnco_pkg::t_word num, qe;
    mlnco_pkg::t_word r_n_dly [mlnco_pkg::MUL_LAT];
    mlnco_pkg::t_word r_n5, r_qe, r_prod, r_b;
    mlnco_pkg::t_word rem, quo;

    mlnco_mulhi u_prod (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_x2),
        .i_b   (i_b),
        .o_hi  (num)
    );

    mlnco_mulhi u_recip (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (num),
        .i_b   (RECIP),
        .o_hi  (qe)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_dly[0] <= num;
            for (int j = 1; j < int'(mlnco_pkg::MUL_LAT); j++) begin
                r_n_dly[j] <= r_n_dly[j-1];
            end
            r_n5   <= r_n_dly[mlnco_pkg::MUL_LAT-1];
            r_qe   <= qe;
            r_prod <= qe * DIV_W;
            r_b    <= mlnco_pkg::ONE_Q63 - quo;
        end
    end

    always_comb begin
        rem = r_n5 - r_prod;
        quo = (rem >= DIV_W) ? (r_qe + 64'd1) : r_qe;
    end

    assign o_b = r_b;

endmodule

`default_nettype wire

@@ rtl/core/mlnco_lane.sv @@
`default_nettype none

// One lane: phase in, rounded cosine and quadrature samples out.
// The phase folds into the first octant, the series gives cos and sin of the
// folded angle, and the quadrant picks and signs the two results.
module mlnco_lane #(
    parameter int unsigned PHASE_BITS  = mlnco_pkg::PHASE_BITS_DEF,
    parameter int unsigned SAMPLE_BITS = mlnco_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [PHASE_BITS-1:0]  i_phase,
    output logic [SAMPLE_BITS-1:0] o_i_sample,
    output logic [SAMPLE_BITS-1:0] o_q_sample
);

    localparam int unsigned XD  = mlnco_pkg::MUL_LAT + mlnco_pkg::TERMS * mlnco_pkg::STEP_LAT;
    localparam int unsigned FD  = 3 * mlnco_pkg::MUL_LAT
                                  + mlnco_pkg::TERMS * mlnco_pkg::STEP_LAT;
    localparam int unsigned X2D = (mlnco_pkg::TERMS - 1) * mlnco_pkg::STEP_LAT;

    localparam mlnco_pkg::t_word        RND    = 64'd1 << (63 - SAMPLE_BITS);
    localparam logic [SAMPLE_BITS-1:0]  MAXPOS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    function automatic logic [SAMPLE_BITS-1:0] to_sample(
        input mlnco_pkg::t_word mag,
        input logic             neg
    );
        mlnco_pkg::t_word       sum;
        logic [SAMPLE_BITS-1:0] v;
        sum = mag + RND;
        v   = sum[63 -: SAMPLE_BITS];
        if (!neg) begin
            return (v > MAXPOS) ? MAXPOS : v;
        end
        return SAMPLE_BITS'(0) - v;
    endfunction

    mlnco_pkg::t_word u, ang_hi, x, x2, s, ct, st;
    logic [61:0]      r_frac, a_fold;
    logic             swap;
    mlnco_pkg::t_word r_a4;
    logic [1:0]       r_quad;
    logic             r_swap;

    mlnco_pkg::t_word r_x_dly    [XD];
    mlnco_pkg::t_word r_x2_dly   [X2D];
    mlnco_pkg::t_word r_c_dly    [mlnco_pkg::MUL_LAT];
    logic [2:0]       r_flag_dly [FD];

    mlnco_pkg::t_word bc_chain [mlnco_pkg::TERMS+1];
    mlnco_pkg::t_word bs_chain [mlnco_pkg::TERMS+1];

    logic [1:0]             quad_f, quad_q;
    logic                   swap_f;
    logic [SAMPLE_BITS-1:0] r_i, r_q;

    // Octant fold: angles past pi/4 within a quadrant swap cos and sin.
    always_comb begin
        u      = mlnco_pkg::t_word'(i_phase) << (64 - PHASE_BITS);
        r_frac = u[61:0];
        swap   = r_frac > 62'h2000_0000_0000_0000;
        a_fold = swap ? (62'd0 - r_frac) : r_frac;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a4   <= {a_fold, 2'b00};
            r_quad <= u[63:62];
            r_swap <= swap;
        end
    end

    mlnco_mulhi u_angle (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_a4),
        .i_b   (mlnco_pkg::PI_QUARTER_Q64),
        .o_hi  (ang_hi)
    );

    assign x = {ang_hi[62:0], 1'b0};

    mlnco_mulhi u_square (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (x),
        .i_b   (x),
        .o_hi  (x2)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_dly[0]    <= x;
            r_x2_dly[0]   <= x2;
            r_c_dly[0]    <= bc_chain[mlnco_pkg::TERMS];
            r_flag_dly[0] <= {r_quad, r_swap};
            for (int j = 1; j < int'(XD); j++) begin
                r_x_dly[j] <= r_x_dly[j-1];
            end
            for (int j = 1; j < int'(X2D); j++) begin
                r_x2_dly[j] <= r_x2_dly[j-1];
            end
            for (int j = 1; j < int'(mlnco_pkg::MUL_LAT); j++) begin
                r_c_dly[j] <= r_c_dly[j-1];
            end
            for (int j = 1; j < int'(FD); j++) begin
                r_flag_dly[j] <= r_flag_dly[j-1];
            end
        end
    end

    assign bc_chain[0] = mlnco_pkg::ONE_Q63;
    assign bs_chain[0] = mlnco_pkg::ONE_Q63;

    for (genvar t = 0; t < int'(mlnco_pkg::TERMS); t++) begin : g_term
        localparam int unsigned K  = mlnco_pkg::TERMS - t;
        localparam int unsigned DC = (2 * K - 1) * (2 * K);
        localparam int unsigned DS = (2 * K) * (2 * K + 1);

        mlnco_pkg::t_word x2_tap;

        if (t == 0) begin : g_first
            assign x2_tap = x2;
        end else begin : g_later
            assign x2_tap = r_x2_dly[t * mlnco_pkg::STEP_LAT - 1];
        end

        mlnco_step #(.DIV(DC)) u_cos (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (x2_tap),
            .i_b   (bc_chain[t]),
            .o_b   (bc_chain[t+1])
        );

        mlnco_step #(.DIV(DS)) u_sin (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (x2_tap),
            .i_b   (bs_chain[t]),
            .o_b   (bs_chain[t+1])
        );
    end

    mlnco_mulhi u_sine (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_x_dly[XD-1]),
        .i_b   (bs_chain[mlnco_pkg::TERMS]),
        .o_hi  (s)
    );

    // Quadrant map: odd quadrants take the sine, quadrants one and two negate.
    // The quadrature sample sits one quadrant further on.
    always_comb begin
        quad_f = r_flag_dly[FD-1][2:1];
        swap_f = r_flag_dly[FD-1][0];
        quad_q = quad_f + 2'd1;
        ct     = swap_f ? s : r_c_dly[mlnco_pkg::MUL_LAT-1];
        st     = swap_f ? r_c_dly[mlnco_pkg::MUL_LAT-1] : s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i <= to_sample(quad_f[0] ? st : ct, quad_f[1] ^ quad_f[0]);
            r_q <= to_sample(quad_q[0] ? st : ct, quad_q[1] ^ quad_q[0]);
        end
    end

    assign o_i_sample = r_i;
    assign o_q_sample = r_q;

endmodule

`default_nettype wire

@@ rtl/core/multi_lane_iq_nco_top.sv @@
`default_nettype none

// Multi-lane I/Q numerically controlled oscillator. Every request with
// i_tick high returns one beat of LANES consecutive complex samples and then
// advances the phase accumulator by LANES times the programmed phase step;
// a request with i_tick low is taken but returns nothing and leaves the phase
// alone. Lane k sits at phase acc + k*step; o_i_samples carries its cosine
// and o_q_samples its -sine, both signed with SAMPLE_BITS-1 fraction bits,
// rounded to nearest with ties away from zero, +1.0 clipped to the largest
// positive code, lane 0 in the low bits and unused upper bits zero. The block
// takes one request per clock and returns one beat per clock while its skid
// stage is empty. The lane phases are registered at the edge that takes the
// request; from there a lane spends one stage folding the phase, two on the
// angle product and two on its square (each a 64x64 high product built from
// 32x32 partial products), sixty on ten series terms of six stages each with
// the cosine and sine chains side by side, two on the final sine product and
// one on rounding, and the output register follows.
// Program phase_step through i_cfg_we and i_cfg_wdata only while no request
// is in flight. The output has a one-beat skid stage, so a request is still
// taken while a finished beat waits for i_res_ready.
module multi_lane_iq_nco_top #(
    parameter int unsigned PHASE_BITS  = mlnco_pkg::PHASE_BITS_DEF,
    parameter int unsigned LANES       = mlnco_pkg::LANES_DEF,
    parameter int unsigned SAMPLE_BITS = mlnco_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic                          i_tick,
    input  logic                          i_cfg_we,
    input  logic [mlnco_pkg::STEP_W-1:0]  i_cfg_wdata,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [mlnco_pkg::WORD_W-1:0]  o_i_samples,
    output logic [mlnco_pkg::WORD_W-1:0]  o_q_samples
);

    localparam int unsigned LAT = mlnco_pkg::LANE_LAT;

    logic                          en, take, pipe_fire, out_free;
    logic [mlnco_pkg::STEP_W-1:0]  r_step;
    logic [PHASE_BITS-1:0]         r_acc, step_p;
    logic [PHASE_BITS-1:0]         r_phase [LANES];
    logic [LAT:0]                  r_vld;
    logic [SAMPLE_BITS-1:0]        lane_i  [LANES];
    logic [SAMPLE_BITS-1:0]        lane_q  [LANES];
    mlnco_pkg::t_word              pipe_i, pipe_q;
    mlnco_pkg::t_word              r_out_i, r_out_q, r_skid_i, r_skid_q;
    logic                          r_out_valid, r_skid_valid;

    // The whole lane pipeline moves together; it stops only while the skid
    // stage holds a beat, which is exactly when the output side is full.
    assign en          = !r_skid_valid;
    assign o_req_ready = en;
    assign take        = i_req_valid && en && i_tick;
    assign pipe_fire   = en && r_vld[LAT];
    assign out_free    = !r_out_valid || i_res_ready;

    // Only the low PHASE_BITS bits of the step take part.
    assign step_p = PHASE_BITS'(mlnco_pkg::t_word'(r_step));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_acc        <= '0;
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (take) begin
                r_acc <= r_acc + PHASE_BITS'(LANES) * step_p;
            end
            if (en) begin
                r_vld <= {r_vld[LAT-1:0], take};
            end
            if (out_free) begin
                r_out_valid  <= r_skid_valid || pipe_fire;
                r_skid_valid <= 1'b0;
            end else if (pipe_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Lane phases for the beat, registered at the pipeline entry.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < int'(LANES); k++) begin
                r_phase[k] <= r_acc + PHASE_BITS'(k) * step_p;
            end
        end
    end

    for (genvar k = 0; k < int'(LANES); k++) begin : g_lane
        mlnco_lane #(
            .PHASE_BITS  (PHASE_BITS),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_phase    (r_phase[k]),
            .o_i_sample (lane_i[k]),
            .o_q_sample (lane_q[k])
        );
    end

    // Merge the lanes into the packed words, lane 0 lowest.
    always_comb begin
        pipe_i = '0;
        pipe_q = '0;
        for (int k = 0; k < int'(LANES); k++) begin
            pipe_i[k*SAMPLE_BITS +: SAMPLE_BITS] = lane_i[k];
            pipe_q[k*SAMPLE_BITS +: SAMPLE_BITS] = lane_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_i <= r_skid_valid ? r_skid_i : pipe_i;
            r_out_q <= r_skid_valid ? r_skid_q : pipe_q;
        end else if (pipe_fire) begin
            r_skid_i <= pipe_i;
            r_skid_q <= pipe_q;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_i_samples = r_out_i;
    assign o_q_samples = r_out_q;

`ifndef SYNTH
    // The skid stage only fills behind a beat that is waiting at the output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat with the output empty");

    // A beat leaving the pipeline while the output is blocked lands in the skid stage.
    a_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_fire && !out_free) |=> r_skid_valid)
        else $error("beat dropped while the output was blocked");

    // A stalled pipeline keeps every beat in place.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    // Each beat advances the phase by LANES steps.
    a_phase_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_acc == $past(r_acc + PHASE_BITS'(LANES) * step_p)))
        else $error("phase accumulator advanced by the wrong amount");
`endif

endmodule

`default_nettype wire
